// ----- hw/rtl/rat_norm_pkg.sv -----
// shared constants, command codes and control/status structs for the
// rational arithmetic normaliser; no dependencies
package rat_norm_pkg;

    // operand field width (magnitudes of a two's complement field fit in it)
    localparam int OPERAND_BITS = 16;
    localparam int MAG_W        = OPERAND_BITS;
    localparam int PROD_W       = 2 * OPERAND_BITS;
    localparam int RAW_W        = PROD_W + 1;
    localparam int CNT_W        = $clog2(RAW_W);

    localparam int NUM_W        = 32;
    localparam int DEN_W        = 30;
    localparam int IN_DATA_W    = ((4 * OPERAND_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((NUM_W + DEN_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - NUM_W - DEN_W;
    localparam int LIM_W        = RAW_W + 32;

    localparam logic [LIM_W-1:0] NUM_LIMIT = LIM_W'(32'h7FFF_FFFF);
    localparam logic [LIM_W-1:0] DEN_LIMIT = LIM_W'(32'h3FFF_FFFF);

    // command codes; anything above normalise behaves as normalise
    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NORM = 3'd4;

    // which cross product the shared multiplier forms
    typedef enum logic [1:0] {
        MSEL_P1 = 2'd0,
        MSEL_P2 = 2'd1,
        MSEL_P3 = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic op_error;
        logic sum_zero;
        logic gcd_done;
    } dp_status_t;

endpackage

// ----- hw/rtl/rat_norm_dp.sv -----
// datapath of the rational normaliser: operand registers, shared multiplier,
// binary gcd unit, twin restoring divider and result register; uses rat_norm_pkg
module rat_norm_dp
    import rat_norm_pkg::*;
(
    input  logic                 clk,
    input  dp_cmd_t              cmd,
    input  logic [2:0]           in_command,
    input  logic [IN_DATA_W-1:0] in_data,
    output dp_status_t           status,
    output logic [NUM_W-1:0]     res_num,
    output logic [DEN_W-1:0]     res_den,
    output logic                 res_err
);

    function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] raw);
        mag_of = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
    endfunction

    logic [MAG_W-1:0]  an_raw, ad_raw, bn_raw, bd_raw;
    logic [MAG_W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
    logic              pair_cmd, err_in;

    logic [MAG_W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic              sa_reg, sb_reg, err_reg;
    logic [2:0]        op_reg;
    logic [PROD_W-1:0] p1_reg, p2_reg, p3_reg;
    logic [RAW_W-1:0]  num_reg, den_reg, u_reg, v_reg, rn_reg, rd_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  res_num_reg;
    logic [DEN_W-1:0]  res_den_reg;
    logic              res_err_reg;

    logic [MAG_W-1:0]  mx, my;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  sum, e1, e2;
    logic              sum_neg, s2;

    logic [RAW_W:0]    tn, td, gx;
    logic              qn, qd;
    logic              over, bad;
    logic [NUM_W-1:0]  mag32;

    // operand fields, lowest first
    assign an_raw = in_data[MAG_W-1:0];
    assign ad_raw = in_data[2*MAG_W-1:MAG_W];
    assign bn_raw = in_data[3*MAG_W-1:2*MAG_W];
    assign bd_raw = in_data[4*MAG_W-1:3*MAG_W];
    assign an_mag = mag_of(an_raw);
    assign ad_mag = mag_of(ad_raw);
    assign bn_mag = mag_of(bn_raw);
    assign bd_mag = mag_of(bd_raw);

    assign pair_cmd = (in_command == CMD_ADD) || (in_command == CMD_SUB) ||
                      (in_command == CMD_MUL) || (in_command == CMD_DIV);
    assign err_in   = (ad_mag == '0) || (pair_cmd && (bd_mag == '0)) ||
                      ((in_command == CMD_DIV) && (bn_mag == '0));

    // multiplier operand selection
    always_comb
    begin
        mx = '0;
        my = '0;
        unique case (cmd.mul_sel)
            MSEL_P1:
            begin
                mx = an_reg;
                if (op_reg == CMD_ADD || op_reg == CMD_SUB || op_reg == CMD_DIV)
                    my = bd_reg;
                else if (op_reg == CMD_MUL)
                    my = bn_reg;
                else
                    my = MAG_W'(1);
            end
            MSEL_P2:
            begin
                mx = (op_reg == CMD_ADD || op_reg == CMD_SUB) ? ad_reg : '0;
                my = bn_reg;
            end
            MSEL_P3:
            begin
                mx = ad_reg;
                if (op_reg == CMD_ADD || op_reg == CMD_SUB || op_reg == CMD_MUL)
                    my = bd_reg;
                else if (op_reg == CMD_DIV)
                    my = bn_reg;
                else
                    my = MAG_W'(1);
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mx) * PROD_W'(my);

    // signed combination of the two numerator products
    assign e1 = RAW_W'(p1_reg);
    assign e2 = RAW_W'(p2_reg);
    assign s2 = sb_reg ^ (op_reg == CMD_SUB);

    always_comb
    begin
        if (op_reg == CMD_ADD || op_reg == CMD_SUB)
        begin
            priority if (sa_reg == s2)
            begin
                sum     = e1 + e2;
                sum_neg = sa_reg;
            end
            else if (e1 >= e2)
            begin
                sum     = e1 - e2;
                sum_neg = sa_reg;
            end
            else
            begin
                sum     = e2 - e1;
                sum_neg = s2;
            end
        end
        else
        begin
            sum     = e1;
            sum_neg = (op_reg == CMD_MUL || op_reg == CMD_DIV) ? (sa_reg ^ sb_reg) : sa_reg;
        end
    end

    // divider trial subtractions, both quotients share the divisor
    assign gx = {1'b0, u_reg};
    assign tn = {rn_reg, num_reg[RAW_W-1]};
    assign td = {rd_reg, den_reg[RAW_W-1]};
    assign qn = (tn >= gx);
    assign qd = (td >= gx);

    assign over  = (LIM_W'(num_reg) > NUM_LIMIT) || (LIM_W'(den_reg) > DEN_LIMIT);
    assign bad   = err_reg || over;
    assign mag32 = NUM_W'(num_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg  <= an_mag;
            ad_reg  <= ad_mag;
            bn_reg  <= bn_mag;
            bd_reg  <= bd_mag;
            sa_reg  <= an_raw[MAG_W-1] ^ ad_raw[MAG_W-1];
            sb_reg  <= bn_raw[MAG_W-1] ^ bd_raw[MAG_W-1];
            op_reg  <= in_command;
            err_reg <= err_in;
        end

        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MSEL_P1: p1_reg <= prod;
                MSEL_P2: p2_reg <= prod;
                MSEL_P3: p3_reg <= prod;
                default: p1_reg <= p1_reg;
            endcase
        end

        if (cmd.combine)
        begin
            num_reg <= sum;
            den_reg <= (sum == '0) ? RAW_W'(1) : RAW_W'(p3_reg);
            neg_reg <= (sum == '0) ? 1'b0 : sum_neg;
            u_reg   <= sum;
            v_reg   <= RAW_W'(p3_reg);
        end

        // binary gcd, one step a cycle; common twos leave num and den at once
        if (cmd.gcd_step)
        begin
            priority if (!u_reg[0] && !v_reg[0])
            begin
                u_reg   <= u_reg >> 1;
                v_reg   <= v_reg >> 1;
                num_reg <= num_reg >> 1;
                den_reg <= den_reg >> 1;
            end
            else if (!u_reg[0])
                u_reg <= u_reg >> 1;
            else if (!v_reg[0])
                v_reg <= v_reg >> 1;
            else if (u_reg >= v_reg)
                u_reg <= (u_reg - v_reg) >> 1;
            else
                v_reg <= (v_reg - u_reg) >> 1;
        end

        if (cmd.div_init)
        begin
            u_reg  <= u_reg | v_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end

        if (cmd.div_step)
        begin
            rn_reg  <= qn ? RAW_W'(tn - gx) : tn[RAW_W-1:0];
            rd_reg  <= qd ? RAW_W'(td - gx) : td[RAW_W-1:0];
            num_reg <= {num_reg[RAW_W-2:0], qn};
            den_reg <= {den_reg[RAW_W-2:0], qd};
        end

        if (cmd.out_load)
        begin
            res_num_reg <= bad ? '0 : (neg_reg ? (NUM_W'(0) - mag32) : mag32);
            res_den_reg <= bad ? DEN_W'(1) : DEN_W'(den_reg);
            res_err_reg <= bad;
        end
    end

    assign status.op_error = err_reg;
    assign status.sum_zero = (sum == '0);
    assign status.gcd_done = (u_reg == '0) || (v_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign res_err = res_err_reg;

endmodule

// ----- hw/rtl/rat_norm_ctrl.sv -----
// controller of the rational normaliser: sequencing state machine, divider
// step counter and output valid flag; uses rat_norm_pkg
module rat_norm_ctrl
    import rat_norm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL0 = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_MUL2 = 8'b0000_1000,
        S_COMB = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RAW_W - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                if (status.op_error)
                    state_next = S_FIN;
                else
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MSEL_P1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P2;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_P3;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = status.sum_zero ? S_FIN : S_GCD;
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_FIN;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_FIN:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // the step counter only runs while dividing
    a_cnt_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (state_reg == S_DIV))
        else $error("divider counter running outside divide state");

    // an accepted word always starts the multiply sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_MUL0))
        else $error("accepted word did not start processing");

    // a finished result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && valid_reg && !m_tready) |=> (state_reg == S_FIN))
        else $error("result register loaded while occupied");

endmodule

// ----- hw/rtl/rational_arith_normalize.sv -----
// top level of the rational arithmetic unit with gcd reduction
// joins rat_norm_ctrl and rat_norm_dp; uses rat_norm_pkg
//
// Takes a word holding two fractions a and b and a command (add, subtract,
// multiply, divide, or normalise a alone; unused codes normalise a) and
// returns one word with the result in lowest terms: sign on the numerator,
// denominator positive, zero as 0/1. A zero operand denominator, division
// by a zero fraction, or a reduced result too wide for the output fields
// raises zero_denominator_error and gives 0/1. One word is in flight at a
// time: after it is loaded, the single shared multiplier forms the three
// cross products, these are combined, a data dependent number of binary
// gcd steps runs, the gcd is handed to the restoring divider that forms
// both quotients side by side, and the result goes into the output
// register. Operand errors and zero numerators skip the gcd and divider.
// The output register lets the next word be accepted while a result
// still waits to be taken.
module rational_arith_normalize
    import rat_norm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // a_numerator, a_denominator, b_numerator, b_denominator
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_numerator, result_denominator, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // zero_denominator_error
    output logic                  m_tuser
);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [NUM_W-1:0] res_num;
    logic [DEN_W-1:0] res_den;
    logic             res_err;

    // sequencing
    rat_norm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and result register
    rat_norm_dp u_dp
    (
        .clk        (clk),
        .cmd        (cmd),
        .in_command (s_tuser),
        .in_data    (s_tdata),
        .status     (status),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_err    (res_err)
    );

    assign m_tdata = {OUT_PAD_W'(1'b0), res_den, res_num};
    assign m_tuser = res_err;

    // an error result is always 0/1
    a_err_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (res_num == '0 && res_den == DEN_W'(1)))
        else $error("error word not 0/1");

    // a valid result never has a zero denominator, and zero is written 0/1
    a_den_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_num == '0)) |-> (res_den == DEN_W'(1)))
        else $error("zero result with denominator other than one");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_den != '0))
        else $error("result with zero denominator");

endmodule
